### rtl/fmd_pkg.sv
// Shared types, constants and the CRC-32 byte update of the framed message deframer.
// Used by fmd_out_queue and framed_message_deframer_crc32; depends on nothing.
`timescale 1ns / 1ps

package fmd_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'h5246_5750;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam int          HDR_BYTES  = 24;
    localparam logic [15:0] PHASE_KIND = 16'h0030;
    localparam logic [31:0] ID_BYTES   = 32'd8;
    localparam logic [2:0]  GOOD_MASK  = 3'h7;

    // Register map: register index taken from paddr[2]
    localparam logic        REG_MAX_PAYLOAD = 1'b0;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  payload_out;
        logic [15:0] byte_offset;
        logic        frame_end;
        logic        crc_ok;
        logic        oversize_drop;
        logic        send_ack;
        logic [15:0] msg_kind;
        logic [31:0] seq_number;
        logic [31:0] length_field;
        logic [31:0] phase_word;
        logic [31:0] frame_id;
    } result_t;

    // Reflected CRC-32, one byte, unrolled over its eight bit steps
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### rtl/fmd_out_queue.sv
// Two-entry result queue (output register plus skid entry) of the deframer.
// Depends on fmd_pkg for result_t.
`timescale 1ns / 1ps

module fmd_out_queue
    import fmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // drain the skid entry first
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_next = push_valid;
            out_data_next  = push_data;
        end else if (push_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_valid && skid_valid_reg))
        else $error("item pushed into full result queue");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost under stall");

endmodule

### rtl/framed_message_deframer_crc32.sv
// A result is registered in the result queue before it appears on the output port.
// One byte per cycle while in_stall is low; CRC, header decode and verdict are combinational.
// in_stall rises only when both entries of the two-entry result queue are held.
// Reset (rst_n, async, active low): hunt for magic, counters cleared, CRC at all ones,
// good-frame count 0, max_payload_bytes 65536; the header byte store is not reset.
`timescale 1ns / 1ps

module framed_message_deframer_crc32
    import fmd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic        has_byte,
    output logic [7:0]  payload_out,
    output logic [15:0] byte_offset,
    output logic        frame_end,
    output logic        crc_ok,
    output logic        oversize_drop,
    output logic        send_ack,
    output logic [15:0] msg_kind,
    output logic [31:0] seq_number,
    output logic [31:0] length_field,
    output logic [31:0] phase_word,
    output logic [31:0] frame_id
);

    localparam logic [16:0] PayloadCap = 17'(MAX_PAYLOAD);
    localparam logic [4:0]  HdrLast    = 5'(HDR_BYTES - 1);

    // configuration
    logic [16:0] max_payload_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);
    assign prdata    = (paddr[2] == REG_MAX_PAYLOAD) ? {15'h0, max_payload_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_payload_reg <= 17'h1_0000;
        end else if (cfg_write) begin
            max_payload_reg <= pwdata[16:0];
        end
    end

    // deframer state
    logic        in_payload_reg, in_payload_next;
    logic [4:0]  header_count_reg, header_count_next;
    logic [16:0] payload_count_reg, payload_count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] frame_id_reg, frame_id_next;
    logic [2:0]  good_reg, good_next;
    logic [7:0]  hdr_reg [HDR_BYTES];

    logic        accept;
    logic        queue_full;
    logic        res_valid;
    result_t     res;
    result_t     q_data;
    logic        store_write;
    logic        slide;

    logic [15:0] hdr_kind;
    logic [31:0] hdr_seq, hdr_len, hdr_crc;
    logic [16:0] limit;
    logic [31:0] crc_upd;
    logic [31:0] fin_crc, fin_phase, fin_id;
    logic        fin;
    logic        fin_ok;
    logic [2:0]  good_inc;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    assign hdr_kind = {hdr_reg[7], hdr_reg[6]};
    assign hdr_seq  = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
    assign hdr_len  = {hdr_reg[15], hdr_reg[14], hdr_reg[13], hdr_reg[12]};
    assign hdr_crc  = {hdr_reg[19], hdr_reg[18], hdr_reg[17], hdr_reg[16]};
    assign limit    = (max_payload_reg > PayloadCap) ? PayloadCap : max_payload_reg;
    assign crc_upd  = crc32_byte(crc_reg, rx_byte);
    assign fin_ok   = ((fin_crc ^ CRC_INIT) == hdr_crc);
    assign good_inc = (good_reg + 3'd1) & GOOD_MASK;

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        payload_count_next = payload_count_reg;
        crc_next           = crc_reg;
        phase_next         = phase_reg;
        frame_id_next      = frame_id_reg;
        good_next          = good_reg;
        store_write        = 1'b0;
        slide              = 1'b0;
        res_valid          = 1'b0;
        res                = '0;
        fin                = 1'b0;
        fin_crc            = crc_reg;
        fin_phase          = phase_reg;
        fin_id             = frame_id_reg;

        if (!in_payload_reg) begin
            if (header_count_reg == 5'd3 &&
                {rx_byte, hdr_reg[2], hdr_reg[1], hdr_reg[0]} != MAGIC_WORD) begin
                // slide the magic window by one byte
                slide             = 1'b1;
                header_count_next = 5'd3;
            end else if (header_count_reg != HdrLast) begin
                store_write       = 1'b1;
                header_count_next = header_count_reg + 5'd1;
            end else begin
                store_write       = 1'b1;
                header_count_next = 5'd0;
                res.msg_kind      = hdr_kind;
                res.seq_number    = hdr_seq;
                res.length_field  = hdr_len;
                if (hdr_len > {15'h0, limit}) begin
                    res_valid         = 1'b1;
                    res.oversize_drop = 1'b1;
                end else begin
                    payload_count_next = 17'd0;
                    crc_next           = CRC_INIT;
                    phase_next         = 32'h0;
                    frame_id_next      = 32'h0;
                    if (hdr_len == 32'h0) begin
                        // empty payload: verdict now, CRC of nothing
                        fin       = 1'b1;
                        fin_crc   = CRC_INIT;
                        fin_phase = 32'h0;
                        fin_id    = 32'h0;
                    end else begin
                        in_payload_next = 1'b1;
                    end
                end
            end
        end else begin
            res_valid          = 1'b1;
            res.has_byte       = 1'b1;
            res.payload_out    = rx_byte;
            res.byte_offset    = payload_count_reg[15:0];
            crc_next           = crc_upd;
            if (payload_count_reg < 17'd4) begin
                phase_next = phase_reg | ({24'h0, rx_byte} << {payload_count_reg[1:0], 3'b000});
            end else if (payload_count_reg < 17'd8) begin
                frame_id_next = frame_id_reg |
                                ({24'h0, rx_byte} << {payload_count_reg[1:0], 3'b000});
            end
            payload_count_next = payload_count_reg + 17'd1;
            fin_crc   = crc_next;
            fin_phase = phase_next;
            fin_id    = frame_id_next;
            if ({15'h0, payload_count_next} == hdr_len) begin
                fin = 1'b1;
            end
        end

        if (fin) begin
            res_valid          = 1'b1;
            res.frame_end      = 1'b1;
            res.msg_kind       = hdr_kind;
            res.seq_number     = hdr_seq;
            res.length_field   = hdr_len;
            in_payload_next    = 1'b0;
            header_count_next  = 5'd0;
            payload_count_next = 17'd0;
            if (fin_ok) begin
                good_next    = good_inc;
                res.crc_ok   = 1'b1;
                res.send_ack = (good_inc == 3'd0);
            end
            if (hdr_kind == PHASE_KIND && hdr_len >= ID_BYTES) begin
                res.phase_word = fin_phase;
                res.frame_id   = fin_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_payload_reg    <= 1'b0;
            header_count_reg  <= 5'd0;
            payload_count_reg <= 17'd0;
            crc_reg           <= CRC_INIT;
            phase_reg         <= 32'h0;
            frame_id_reg      <= 32'h0;
            good_reg          <= 3'd0;
        end else if (accept) begin
            in_payload_reg    <= in_payload_next;
            header_count_reg  <= header_count_next;
            payload_count_reg <= payload_count_next;
            crc_reg           <= crc_next;
            phase_reg         <= phase_next;
            frame_id_reg      <= frame_id_next;
            good_reg          <= good_next;
        end
    end

    // header byte store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && slide) begin
            hdr_reg[0] <= hdr_reg[1];
            hdr_reg[1] <= hdr_reg[2];
            hdr_reg[2] <= rx_byte;
        end else if (accept && store_write) begin
            hdr_reg[header_count_reg] <= rx_byte;
        end
    end

    fmd_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept && res_valid),
        .push_data  (res),
        .full       (queue_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (q_data)
    );

    assign has_byte      = q_data.has_byte;
    assign payload_out   = q_data.payload_out;
    assign byte_offset   = q_data.byte_offset;
    assign frame_end     = q_data.frame_end;
    assign crc_ok        = q_data.crc_ok;
    assign oversize_drop = q_data.oversize_drop;
    assign send_ack      = q_data.send_ack;
    assign msg_kind      = q_data.msg_kind;
    assign seq_number    = q_data.seq_number;
    assign length_field  = q_data.length_field;
    assign phase_word    = q_data.phase_word;
    assign frame_id      = q_data.frame_id;

    a_hdr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HdrLast)
        else $error("header count past end of header");

    a_payload_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (header_count_reg == 5'd0 && {15'h0, payload_count_reg} < hdr_len))
        else $error("payload state inconsistent with header length");

    a_ack_only_good: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && res.send_ack) |-> (res.crc_ok && res.frame_end))
        else $error("ack flagged without good frame end");

endmodule
